// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by hsv_to_rgb_led_duty
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/hsvled_pkg.sv -----
// ---------------------------------------------------------------------------
// hsvled_pkg
// types and constants for the hsv to rgb led duty pipeline
// ---------------------------------------------------------------------------
package hsvled_pkg;

    localparam int NUM_STAGES  = 6;
    localparam int SECTOR_DEG  = 60;
    localparam int NUM_SECTORS = 6;

    typedef logic [2:0] t_channel;
    typedef logic [9:0] t_hue;
    typedef logic [7:0] t_level;
    typedef logic [2:0] t_sector;
    typedef logic [5:0] t_frac;

    localparam t_hue   HUE_MAX  = 10'd359;
    localparam t_level VAL_FULL = 8'd255;

    // reciprocal of 60, exact for products up to 255 * 59
    localparam logic [14:0] RECIP_60       = 15'd17477;
    localparam int          RECIP_60_SHIFT = 20;

    // reciprocal of 5, exact for values up to 1020
    localparam logic [10:0] RECIP_5       = 11'd1639;
    localparam int          RECIP_5_SHIFT = 13;

    localparam t_channel CH_FIRST = 3'd1;
    localparam t_channel CH_LAST  = 3'd4;

    localparam t_sector SEC_0 = 3'd0;
    localparam t_sector SEC_1 = 3'd1;
    localparam t_sector SEC_2 = 3'd2;
    localparam t_sector SEC_3 = 3'd3;
    localparam t_sector SEC_4 = 3'd4;
    localparam t_sector SEC_5 = 3'd5;

    typedef struct packed {
        t_channel channel;
        t_hue     hue;
        t_level   saturation;
        t_level   brightness;
    } t_hsv_in;

    typedef struct packed {
        t_channel target_channel;
        logic     write_strobe;
        t_level   red_duty;
        t_level   green_duty;
        t_level   blue_duty;
    } t_rgb_out;

endpackage

// ----- design/hsvled_sector.sv -----
// ---------------------------------------------------------------------------
// hsvled_sector
// clamps hue to 359 and splits it into a 60 degree sector and an offset
// ---------------------------------------------------------------------------
module hsvled_sector (
    input  hsvled_pkg::t_hue    i_hue,
    output hsvled_pkg::t_sector o_sector,
    output hsvled_pkg::t_frac   o_frac
);
    import hsvled_pkg::*;

    logic [8:0] h;
    logic [8:0] base;

    always_comb begin
        h        = (i_hue > HUE_MAX) ? HUE_MAX[8:0] : i_hue[8:0];
        o_sector = SEC_0;
        base     = '0;
        for (int k = 1; k < NUM_SECTORS; k++) begin
            if (h >= 9'(k * SECTOR_DEG)) begin
                o_sector = 3'(k);
                base     = 9'(k * SECTOR_DEG);
            end
        end
        o_frac = 6'(h - base);
    end

endmodule

// ----- design/hsv_to_rgb_led_duty.sv -----
// ---------------------------------------------------------------------------
// hsv_to_rgb_led_duty
// throughput: one transfer per cycle unless the output is stalled, six-stage pipeline with stall chaining
// reset: clears all stage valid bits, payload registers are not reset
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv_to_rgb_led_duty (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  hsvled_pkg::t_hsv_in  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output hsvled_pkg::t_rgb_out o_data
);
    import hsvled_pkg::*;

    localparam int LAST = NUM_STAGES - 1;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] en;

    // stage 0: hue split, v * (255 - s)
    t_sector     sec0;
    t_frac       frac0;
    logic [15:0] n_prod;
    t_channel    r_s0_ch;
    t_level      r_s0_v;
    t_sector     r_s0_sector;
    t_frac       r_s0_frac;
    logic [15:0] r_s0_prod;

    // stage 1: vmin = prod / 255
    logic [15:0] n_vsum;
    t_level      n_vmin;
    t_channel    r_s1_ch;
    t_level      r_s1_v;
    t_sector     r_s1_sector;
    t_frac       r_s1_frac;
    t_level      r_s1_vmin;
    t_level      r_s1_d;

    // stage 2: (v - vmin) * frac
    logic [13:0] n_m;
    t_channel    r_s2_ch;
    t_level      r_s2_v;
    t_sector     r_s2_sector;
    t_level      r_s2_vmin;
    logic [13:0] r_s2_m;

    // stage 3: alpha = m / 60
    logic [28:0] n_q;
    t_channel    r_s3_ch;
    t_level      r_s3_v;
    t_sector     r_s3_sector;
    t_level      r_s3_vmin;
    t_level      r_s3_alpha;

    // stage 4: sector mux
    t_level      vinc;
    t_level      vdec;
    t_level      n_r;
    t_level      n_g;
    t_level      n_b;
    t_channel    r_s4_ch;
    t_level      r_s4_r;
    t_level      r_s4_g;
    t_level      r_s4_b;

    // stage 5: color balance, output register
    logic [9:0]  b3;
    logic [20:0] g_q;
    logic [20:0] b_q;
    t_rgb_out    n_out;
    t_rgb_out    r_out;

    // stall chain
    always_comb begin
        en[LAST] = !r_vld[LAST] || !i_stall;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld = {r_vld[NUM_STAGES-2:0], i_valid};
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[LAST];
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // stage 0
    hsvled_sector u_sector (
        .i_hue    (i_data.hue),
        .o_sector (sec0),
        .o_frac   (frac0)
    );

    assign n_prod = 16'(i_data.brightness) * 16'(VAL_FULL - i_data.saturation);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0_ch     <= i_data.channel;
            r_s0_v      <= i_data.brightness;
            r_s0_sector <= sec0;
            r_s0_frac   <= frac0;
            r_s0_prod   <= n_prod;
        end
    end

    // stage 1
    always_comb begin
        n_vsum = r_s0_prod + 16'(r_s0_prod[15:8]) + 16'd1;
        n_vmin = n_vsum[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1_ch     <= r_s0_ch;
            r_s1_v      <= r_s0_v;
            r_s1_sector <= r_s0_sector;
            r_s1_frac   <= r_s0_frac;
            r_s1_vmin   <= n_vmin;
            r_s1_d      <= r_s0_v - n_vmin;
        end
    end

    // stage 2
    assign n_m = 14'(r_s1_d) * 14'(r_s1_frac);

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s2_ch     <= r_s1_ch;
            r_s2_v      <= r_s1_v;
            r_s2_sector <= r_s1_sector;
            r_s2_vmin   <= r_s1_vmin;
            r_s2_m      <= n_m;
        end
    end

    // stage 3
    assign n_q = 29'(r_s2_m) * 29'(RECIP_60);

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s3_ch     <= r_s2_ch;
            r_s3_v      <= r_s2_v;
            r_s3_sector <= r_s2_sector;
            r_s3_vmin   <= r_s2_vmin;
            r_s3_alpha  <= n_q[RECIP_60_SHIFT+7:RECIP_60_SHIFT];
        end
    end

    // stage 4
    always_comb begin
        vinc = r_s3_vmin + r_s3_alpha;
        vdec = r_s3_v - r_s3_alpha;
        case (r_s3_sector)
            SEC_0: begin
                n_r = r_s3_v;    n_g = vinc;      n_b = r_s3_vmin;
            end
            SEC_1: begin
                n_r = vdec;      n_g = r_s3_v;    n_b = r_s3_vmin;
            end
            SEC_2: begin
                n_r = r_s3_vmin; n_g = r_s3_v;    n_b = vinc;
            end
            SEC_3: begin
                n_r = r_s3_vmin; n_g = vdec;      n_b = r_s3_v;
            end
            SEC_4: begin
                n_r = vinc;      n_g = r_s3_vmin; n_b = r_s3_v;
            end
            SEC_5: begin
                n_r = r_s3_v;    n_g = r_s3_vmin; n_b = vdec;
            end
            default: begin
                n_r = '0;        n_g = '0;        n_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_s4_ch <= r_s3_ch;
            r_s4_r  <= n_r;
            r_s4_g  <= n_g;
            r_s4_b  <= n_b;
        end
    end

    // stage 5: green * 4 / 5, blue * 3 / 5
    always_comb begin
        b3  = 10'(r_s4_b) * 10'd3;
        g_q = 21'({r_s4_g, 2'b00}) * 21'(RECIP_5);
        b_q = 21'(b3) * 21'(RECIP_5);
        n_out.target_channel = r_s4_ch;
        n_out.write_strobe   = (r_s4_ch inside {[CH_FIRST:CH_LAST]});
        n_out.red_duty       = r_s4_r;
        n_out.green_duty     = g_q[RECIP_5_SHIFT+7:RECIP_5_SHIFT];
        n_out.blue_duty      = b_q[RECIP_5_SHIFT+7:RECIP_5_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_out <= n_out;
        end
    end

    `ASSERT_AT(a_stall_when_full, i_clk, i_rst_n, !o_stall || (&r_vld))
    `ASSERT_AT(a_vmin_le_v, i_clk, i_rst_n, !r_vld[1] || (r_s1_vmin <= r_s1_v))
    `ASSERT_NEXT(a_alpha_in_range, i_clk, i_rst_n, r_vld[2] && en[3],
        r_vld[3] && (r_s3_alpha <= (r_s3_v - r_s3_vmin)))

endmodule

// ----- verif/hsv_duty_checker.sv -----
// ---------------------------------------------------------------------------
// hsv_duty_checker
// watches both transfer channels of the hsv to rgb led duty pipeline, works
// out the duty values for each accepted request and compares every accepted
// result field by field with the oldest outstanding prediction
// ---------------------------------------------------------------------------
module hsv_duty_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_stall,
    input  hsvled_pkg::t_hsv_in  i_req,
    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  hsvled_pkg::t_rgb_out i_res,
    output int                   o_fail_count,
    output int                   o_outstanding,
    output int                   o_checked,
    output int                   o_strobes
);
    timeunit 1ns;
    timeprecision 1ps;
    import hsvled_pkg::*;

    t_rgb_out expected_duty_q[$];
    t_rgb_out want;
    int       fail_count    = 0;
    int       checked_count = 0;
    int       strobe_count  = 0;
    int       pending_count = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = pending_count;
    assign o_checked     = checked_count;
    assign o_strobes     = strobe_count;

    function automatic t_rgb_out predict_duty(input t_hsv_in req);
        t_hue        h;
        t_sector     sector;
        t_frac       frac;
        logic [15:0] dim_prod;
        logic [13:0] span_prod;
        t_level      vmin;
        t_level      alpha;
        t_level      vinc;
        t_level      vdec;
        t_level      v;
        t_level      r;
        t_level      g;
        t_level      b;
        t_rgb_out    res;
        v = req.brightness;
        h = (req.hue > HUE_MAX) ? HUE_MAX : req.hue;
        sector = t_sector'(h / SECTOR_DEG);
        frac   = t_frac'(h % SECTOR_DEG);
        dim_prod  = 16'(v) * 16'(VAL_FULL - req.saturation);
        vmin      = t_level'(dim_prod / VAL_FULL);
        span_prod = 14'(v - vmin) * 14'(frac);
        alpha     = t_level'(span_prod / SECTOR_DEG);
        vinc = vmin + alpha;
        vdec = v - alpha;
        case (sector)
            SEC_0: begin
                r = v;    g = vinc; b = vmin;
            end
            SEC_1: begin
                r = vdec; g = v;    b = vmin;
            end
            SEC_2: begin
                r = vmin; g = v;    b = vinc;
            end
            SEC_3: begin
                r = vmin; g = vdec; b = v;
            end
            SEC_4: begin
                r = vinc; g = vmin; b = v;
            end
            default: begin
                r = v;    g = vmin; b = vdec;
            end
        endcase
        res.target_channel = req.channel;
        res.write_strobe   = (req.channel >= CH_FIRST) && (req.channel <= CH_LAST);
        res.red_duty       = r;
        // color balance on green and blue
        res.green_duty     = t_level'((10'(g) * 4) / 5);
        res.blue_duty      = t_level'((10'(b) * 3) / 5);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, exp_val);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_duty_q.delete();
            pending_count <= 0;
        end else begin
            if (i_req_valid && !i_req_stall) begin
                expected_duty_q.push_back(predict_duty(i_req));
            end
            if (i_res_valid && !i_res_stall) begin
                if (expected_duty_q.size() == 0) begin
                    report_mismatch("result with nothing outstanding", 32'(i_res), '0);
                end else begin
                    want = expected_duty_q.pop_front();
                    checked_count++;
                    if (i_res.write_strobe === 1'b1) begin
                        strobe_count++;
                    end
                    if (i_res.target_channel !== want.target_channel) begin
                        report_mismatch("target_channel", 32'(i_res.target_channel),
                                        32'(want.target_channel));
                    end
                    if (i_res.write_strobe !== want.write_strobe) begin
                        report_mismatch("write_strobe", 32'(i_res.write_strobe),
                                        32'(want.write_strobe));
                    end
                    if (i_res.red_duty !== want.red_duty) begin
                        report_mismatch("red_duty", 32'(i_res.red_duty),
                                        32'(want.red_duty));
                    end
                    if (i_res.green_duty !== want.green_duty) begin
                        report_mismatch("green_duty", 32'(i_res.green_duty),
                                        32'(want.green_duty));
                    end
                    if (i_res.blue_duty !== want.blue_duty) begin
                        report_mismatch("blue_duty", 32'(i_res.blue_duty),
                                        32'(want.blue_duty));
                    end
                end
            end
            pending_count <= expected_duty_q.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// stimulus and verdict for the hsv to rgb led duty pipeline: directed color
// requests at the field extremes and sector edges, then random requests with
// random idle bursts on both channels, a full drain in the middle and a
// stretch without idling; checking is done by the duty checker
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hsvled_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 24;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_stall;
    t_hsv_in  i_data  = '0;
    logic     o_valid;
    logic     i_stall = 1'b0;
    t_rgb_out o_data;

    bit tx_idle_on    = 1'b0;
    bit rx_idle_on    = 1'b0;
    int rx_burst      = 0;
    int cycle_count   = 0;
    int sent_count    = 0;
    int clamped_count = 0;
    int fail_count;
    int outstanding;
    int checked;
    int strobes;

    hsv_to_rgb_led_duty uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    hsv_duty_checker duty_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_req         (i_data),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_res         (o_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_strobes     (strobes)
    );

    always begin
        #5ns i_clk = 1'b1;
        #5ns i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("FAIL hsv_to_rgb_led_duty");
            $finish;
        end
    end

    // result side back-pressure in bursts of random length while rx_idle_on is set
    always @(posedge i_clk) begin
        if (rx_burst > 0) begin
            rx_burst <= rx_burst - 1;
            i_stall  <= 1'b1;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rx_burst <= $urandom_range(0, 4);
            i_stall  <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic t_hsv_in make_request(input int ch, input int hue, input int sat,
                                             input int bright);
        t_hsv_in req;
        req.channel    = t_channel'(ch);
        req.hue        = t_hue'(hue);
        req.saturation = t_level'(sat);
        req.brightness = t_level'(bright);
        return req;
    endfunction

    function automatic t_level random_level();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return VAL_FULL;
            default: return t_level'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_hsv_in random_request();
        t_hsv_in req;
        req.channel = t_channel'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
            0:       req.hue = t_hue'($urandom_range(0, 1023));
            1:       req.hue = t_hue'(SECTOR_DEG * $urandom_range(0, NUM_SECTORS - 1)
                                      + ($urandom_range(0, 1) ? SECTOR_DEG - 1 : 0));
            default: req.hue = t_hue'($urandom_range(0, HUE_MAX));
        endcase
        req.saturation = random_level();
        req.brightness = random_level();
        return req;
    endfunction

    task automatic send_request(input t_hsv_in req);
        int gap;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
        if (req.hue > HUE_MAX) begin
            clamped_count++;
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    initial begin
        t_hsv_in directed_q[$];
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;

        // extremes, sector edges, hue clamping and every channel number
        directed_q.push_back(make_request(0, 0, 255, 255));
        directed_q.push_back(make_request(1, 59, 255, 255));
        directed_q.push_back(make_request(2, 60, 255, 255));
        directed_q.push_back(make_request(3, 119, 128, 200));
        directed_q.push_back(make_request(4, 120, 255, 255));
        directed_q.push_back(make_request(5, 180, 255, 255));
        directed_q.push_back(make_request(6, 240, 200, 100));
        directed_q.push_back(make_request(7, 300, 255, 255));
        directed_q.push_back(make_request(1, 359, 255, 255));
        directed_q.push_back(make_request(2, 360, 255, 255));
        directed_q.push_back(make_request(3, 1023, 255, 255));
        directed_q.push_back(make_request(4, 512, 0, 255));
        directed_q.push_back(make_request(1, 200, 0, 0));
        directed_q.push_back(make_request(2, 30, 0, 255));
        directed_q.push_back(make_request(3, 30, 255, 0));
        directed_q.push_back(make_request(4, 90, 1, 254));
        directed_q.push_back(make_request(0, 270, 255, 1));
        directed_q.push_back(make_request(1, 330, 127, 128));
        directed_q.push_back(make_request(2, 45, 170, 85));
        directed_q.push_back(make_request(3, 150, 85, 170));
        directed_q.push_back(make_request(4, 210, 255, 255));
        directed_q.push_back(make_request(1, 1, 254, 255));
        directed_q.push_back(make_request(2, 299, 255, 254));
        foreach (directed_q[k]) send_request(directed_q[k]);

        repeat (400) send_request(random_request());

        // hold off until the pipeline is empty
        i_valid <= 1'b0;
        wait_drained();

        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        repeat (250) send_request(random_request());

        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
        repeat (200) send_request(random_request());

        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        repeat (50) send_request(random_request());

        i_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d color requests over all channels and sectors, %0d with hue above 359",
                 sent_count, clamped_count);
        $display("%0d results checked, %0d with write strobe, %0d mismatches",
                 checked, strobes, fail_count);
        if (fail_count == 0) begin
            $display("PASS hsv_to_rgb_led_duty");
        end else begin
            $display("FAIL hsv_to_rgb_led_duty");
        end
        $finish;
    end

endmodule
